[sv/ntrs_pkg.sv]
package ntrs_pkg;

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_APPEND = 3'd1,
      CMD_GRID   = 3'd2,
      CMD_LOOKUP = 3'd3,
      CMD_FIRST  = 3'd4,
      CMD_BEST   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_READ = 2'd1,
      S_SCAN = 2'd2,
      S_DONE = 2'd3
   } state_type;

   localparam int GridCells = 9;

   // heading quadrant bounds in degrees
   localparam logic [8:0] HeadEast  = 9'd45;
   localparam logic [8:0] HeadSouth = 9'd135;
   localparam logic [8:0] HeadWest  = 9'd225;
   localparam logic [8:0] HeadNorth = 9'd315;
   localparam logic [1:0] DwellMax  = 2'd3;

   // result of matching one hash against the grid
   typedef struct packed {
      logic       hit;
      logic [1:0] row;
      logic [1:0] col;
   } match_type;

endpackage

[sv/ntrs_ram.sv]
module ntrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[sv/ntrs_grid.sv]
// grid cell store with nine parallel compares
module ntrs_grid (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [1:0]          wr_row,
   input  logic [1:0]          wr_col,
   input  logic [63:0]         wr_hash,
   input  logic [63:0]         probe_hash,
   output ntrs_pkg::match_type match
);

   logic [63:0] cell_ff [ntrs_pkg::GridCells];
   logic [3:0]  wr_idx;

   assign wr_idx = 4'(wr_row) * 4'd3 + 4'(wr_col);

   // row-major cell storage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ntrs_pkg::GridCells; i++) cell_ff[i] <= '0;
      end else if (wr_en && wr_row < 2'd3 && wr_col < 2'd3) begin
         cell_ff[wr_idx] <= wr_hash;
      end
   end

   // first match in row-major order
   always_comb begin
      match = '0;
      for (int i = ntrs_pkg::GridCells - 1; i >= 0; i--) begin
         if (cell_ff[i] == probe_hash) begin
            match.hit = 1'b1;
            match.row = 2'(i / 3);
            match.col = 2'(i % 3);
         end
      end
   end

endmodule

[sv/neighbor_table_relay_select_core.sv]
// channel | ports                                         | direction
// req     | req_command/node_address/cell_hash/heading/.. | in, start/busy
// rsp     | rsp_status/entry_index/found_hash/dwell_time  | out, rsp_valid strobe
// clear, append and grid load step through the read and done states.
// searches walk the table one entry a cycle through the registered ram read
// port; a best dwell of 3 stops the walk.
// busy is high from acceptance until the result strobe.
// synchronous reset empties the table and zeroes the grid.
// the result strobe lasts one cycle; the receiver cannot stall it.
module neighbor_table_relay_select_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_node_address,
   input  logic [63:0] req_cell_hash,
   input  logic [8:0]  req_heading,
   input  logic [1:0]  req_cell_row,
   input  logic [1:0]  req_cell_column,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_entry_index,
   output logic [63:0] rsp_found_hash,
   output logic [1:0]  rsp_dwell_time
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   ntrs_pkg::state_type state_ff, state_in;
   logic [2:0]  cmd_ff;
   logic [31:0] addr_ff;
   logic [63:0] hash_ff;
   logic [8:0]  head_ff;
   logic [1:0]  row_ff, col_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;   // address being fetched
   logic [CW-1:0] ex_ptr_ff, ex_ptr_in;   // entry whose data is on the read port
   logic        have_ff, have_in;
   logic [1:0]  best_ff, best_in;
   logic [AW-1:0] bidx_ff, bidx_in;
   logic [1:0]  status_ff, status_in;
   logic [63:0] fhash_ff, fhash_in;
   logic        valid_ff, valid_in;

   logic        wr_en, grid_wr;
   logic [31:0] rd_addr_q;
   logic [63:0] rd_hash_q;
   logic [8:0]  rd_head_q;
   ntrs_pkg::match_type match;
   logic [1:0]  dwell;

   ntrs_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_addr (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]), .wr_data(addr_ff),
      .rd_addr(rd_ptr_ff), .rd_data(rd_addr_q));
   ntrs_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_hash (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]), .wr_data(hash_ff),
      .rd_addr(rd_ptr_ff), .rd_data(rd_hash_q));
   ntrs_ram #(.WIDTH(9), .DEPTH(TABLE_DEPTH)) u_head (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]), .wr_data(head_ff),
      .rd_addr(rd_ptr_ff), .rd_data(rd_head_q));

   ntrs_grid u_grid (
      .clock(clock), .reset(reset), .wr_en(grid_wr), .wr_row(row_ff), .wr_col(col_ff),
      .wr_hash(hash_ff), .probe_hash(rd_hash_q), .match(match));

   // dwell from heading quadrant
   always_comb begin
      if (rd_head_q >= ntrs_pkg::HeadEast && rd_head_q < ntrs_pkg::HeadSouth) begin
         dwell = match.col;
      end else if (rd_head_q >= ntrs_pkg::HeadWest && rd_head_q < ntrs_pkg::HeadNorth) begin
         dwell = match.col + 2'd1;
      end else if (rd_head_q >= ntrs_pkg::HeadSouth && rd_head_q < ntrs_pkg::HeadWest) begin
         dwell = match.row;
      end else begin
         dwell = match.row + 2'd1;
      end
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntrs_pkg::S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      rd_ptr_ff <= rd_ptr_in;
      ex_ptr_ff <= ex_ptr_in;
      have_ff   <= have_in;
      best_ff   <= best_in;
      bidx_ff   <= bidx_in;
      status_ff <= status_in;
      fhash_ff  <= fhash_in;
      if (start && state_ff == ntrs_pkg::S_IDLE) begin
         cmd_ff  <= req_command;
         addr_ff <= req_node_address;
         hash_ff <= req_cell_hash;
         head_ff <= req_heading;
         row_ff  <= req_cell_row;
         col_ff  <= req_cell_column;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      ex_ptr_in = ex_ptr_ff;
      have_in   = have_ff;
      best_in   = best_ff;
      bidx_in   = bidx_ff;
      status_in = status_ff;
      fhash_in  = fhash_ff;
      valid_in  = 1'b0;
      wr_en     = 1'b0;
      grid_wr   = 1'b0;
      case (state_ff)
         ntrs_pkg::S_IDLE: begin
            if (start) begin
               state_in  = ntrs_pkg::S_READ;
               rd_ptr_in = '0;
               ex_ptr_in = '0;
               have_in   = 1'b0;
               best_in   = '0;
               bidx_in   = '0;
               fhash_in  = '0;
               status_in = ntrs_pkg::ST_NOTFOUND;
            end
         end
         ntrs_pkg::S_READ: begin
            state_in = ntrs_pkg::S_DONE;
            case (cmd_ff)
               ntrs_pkg::CMD_CLEAR: begin
                  count_in  = '0;
                  status_in = ntrs_pkg::ST_OK;
               end
               ntrs_pkg::CMD_APPEND: begin
                  if (count_ff >= CW'(TABLE_DEPTH)) begin
                     status_in = ntrs_pkg::ST_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     bidx_in   = count_ff[AW-1:0];
                     count_in  = count_ff + CW'(1);
                     status_in = ntrs_pkg::ST_OK;
                  end
               end
               ntrs_pkg::CMD_GRID: begin
                  grid_wr   = 1'b1;
                  status_in = ntrs_pkg::ST_OK;
               end
               ntrs_pkg::CMD_LOOKUP, ntrs_pkg::CMD_FIRST, ntrs_pkg::CMD_BEST: begin
                  // entry 0 is being fetched this cycle
                  rd_ptr_in = rd_ptr_ff + AW'(1);
                  if (count_ff != '0) state_in = ntrs_pkg::S_SCAN;
               end
               default: ;
            endcase
         end
         ntrs_pkg::S_SCAN: begin
            // examine entry ex_ptr on the read port, fetch the next
            rd_ptr_in = rd_ptr_ff + AW'(1);
            ex_ptr_in = ex_ptr_ff + CW'(1);
            if (ex_ptr_ff + CW'(1) >= count_ff) state_in = ntrs_pkg::S_DONE;
            case (cmd_ff)
               ntrs_pkg::CMD_LOOKUP: begin
                  if (rd_addr_q == addr_ff) begin
                     status_in = ntrs_pkg::ST_OK;
                     bidx_in   = ex_ptr_ff[AW-1:0];
                     fhash_in  = rd_hash_q;
                     state_in  = ntrs_pkg::S_DONE;
                  end
               end
               ntrs_pkg::CMD_FIRST: begin
                  if (match.hit) begin
                     status_in = ntrs_pkg::ST_OK;
                     bidx_in   = ex_ptr_ff[AW-1:0];
                     state_in  = ntrs_pkg::S_DONE;
                  end
               end
               default: begin
                  if (match.hit) begin
                     if (!have_ff || dwell > best_ff) begin
                        have_in   = 1'b1;
                        best_in   = dwell;
                        bidx_in   = ex_ptr_ff[AW-1:0];
                        status_in = ntrs_pkg::ST_OK;
                     end
                     if (dwell == ntrs_pkg::DwellMax) state_in = ntrs_pkg::S_DONE;
                  end
               end
            endcase
         end
         default: begin
            valid_in = 1'b1;
            state_in = ntrs_pkg::S_IDLE;
         end
      endcase
   end

   assign busy            = state_ff != ntrs_pkg::S_IDLE;
   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_index = 6'(bidx_ff);
   assign rsp_found_hash  = fhash_ff;
   assign rsp_dwell_time  = best_ff;

endmodule

[sv/ntrs_checker.sv]
module ntrs_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [63:0] rsp_found_hash,
   input logic [1:0] rsp_dwell_time
);

   // accepted beat raises busy next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");

   // result strobe only as busy drops
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy)) else $error("stray result");

   // result is one cycle wide
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result too long");

   // not found carries zero payload
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ntrs_pkg::ST_NOTFOUND |->
         rsp_found_hash == '0 && rsp_dwell_time == '0)
      else $error("nonzero payload on miss");

endmodule

bind neighbor_table_relay_select_core ntrs_checker u_ntrs_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_status(rsp_status), .rsp_found_hash(rsp_found_hash),
   .rsp_dwell_time(rsp_dwell_time));

[bench/neighbor_table_relay_select_checker.sv]
module neighbor_table_relay_select_checker
   import ntrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_node_address,
   input  logic [63:0] req_cell_hash,
   input  logic [8:0]  req_heading,
   input  logic [1:0]  req_cell_row,
   input  logic [1:0]  req_cell_column,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [5:0]  rsp_entry_index,
   input  logic [63:0] rsp_found_hash,
   input  logic [1:0]  rsp_dwell_time,
   output int          fail_count,
   output int          pending,
   output int          rsp_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 64;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  index;
      logic [63:0] fhash;
      logic [1:0]  dwell;
   } reply_type;

   logic [31:0] tbl_addr [Depth];
   logic [63:0] tbl_hash [Depth];
   logic [8:0]  tbl_head [Depth];
   int          tbl_count;
   logic [63:0] grid [GridCells];
   reply_type   awaited [$];

   // first grid cell holding this hash, row-major
   function automatic match_type grid_hit(logic [63:0] h);
      match_type m;
      m = '0;
      for (int k = 0; k < GridCells; k++)
         if (!m.hit && grid[k] == h) begin
            m.hit = 1'b1;
            m.row = 2'(k / 3);
            m.col = 2'(k % 3);
         end
      return m;
   endfunction

   function automatic logic [1:0] dwell_for(logic [8:0] hd, match_type m);
      if (hd >= HeadEast && hd < HeadSouth) return m.col;
      if (hd >= HeadWest && hd < HeadNorth) return m.col + 2'd1;
      if (hd >= HeadSouth && hd < HeadWest) return m.row;
      return m.row + 2'd1;
   endfunction

   // advance the table state and work out the reply to one command beat
   function automatic reply_type relay_predict(logic [2:0] cmd, logic [31:0] a,
         logic [63:0] h, logic [8:0] hd, logic [1:0] r, logic [1:0] c);
      reply_type y;
      match_type m;
      logic [1:0] d;
      bit have, stop;
      y = '0;
      y.status = ST_NOTFOUND;
      have = 0;
      stop = 0;
      case (cmd)
         CMD_CLEAR: begin
            tbl_count = 0;
            y.status = ST_OK;
         end
         CMD_APPEND: begin
            if (tbl_count >= Depth) y.status = ST_FULL;
            else begin
               tbl_addr[tbl_count] = a;
               tbl_hash[tbl_count] = h;
               tbl_head[tbl_count] = hd;
               y.index = 6'(tbl_count);
               tbl_count++;
               y.status = ST_OK;
            end
         end
         CMD_GRID: begin
            if (r < 3 && c < 3) grid[r * 3 + c] = h;
            y.status = ST_OK;
         end
         CMD_LOOKUP: begin
            for (int i = 0; i < tbl_count && !stop; i++)
               if (tbl_addr[i] == a) begin
                  y.status = ST_OK;
                  y.index = 6'(i);
                  y.fhash = tbl_hash[i];
                  stop = 1;
               end
         end
         CMD_FIRST: begin
            for (int i = 0; i < tbl_count && !stop; i++)
               if (grid_hit(tbl_hash[i]).hit) begin
                  y.status = ST_OK;
                  y.index = 6'(i);
                  stop = 1;
               end
         end
         CMD_BEST: begin
            for (int i = 0; i < tbl_count && !stop; i++) begin
               m = grid_hit(tbl_hash[i]);
               if (m.hit) begin
                  d = dwell_for(tbl_head[i], m);
                  if (!have || d > y.dwell) begin
                     have = 1;
                     y.dwell = d;
                     y.index = 6'(i);
                  end
                  if (d == DwellMax) stop = 1;
               end
            end
            if (have) y.status = ST_OK;
         end
         default: ;
      endcase
      return y;
   endfunction

   assign pending = awaited.size();

   // predict on accepted command beats, compare on result beats
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         tbl_count = 0;
         foreach (grid[k]) grid[k] = '0;
         awaited.delete();
         fail_count = 0;
         rsp_seen = 0;
      end else begin
         if (rsp_valid) begin
            rsp_seen++;
            if (awaited.size() == 0) begin
               $error("result beat with no expectation waiting");
               fail_count++;
            end else begin
               want = awaited.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_entry_index !== want.index) begin
                  $error("entry_index expected %0d actual %0d", want.index,
                         rsp_entry_index);
                  fail_count++;
               end
               if (rsp_found_hash !== want.fhash) begin
                  $error("found_hash expected %h actual %h", want.fhash, rsp_found_hash);
                  fail_count++;
               end
               if (rsp_dwell_time !== want.dwell) begin
                  $error("dwell_time expected %0d actual %0d", want.dwell,
                         rsp_dwell_time);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            awaited.push_back(relay_predict(req_command, req_node_address,
                  req_cell_hash, req_heading, req_cell_row, req_cell_column));
      end
   end
endmodule

[bench/neighbor_table_relay_select_core_tb.sv]
module neighbor_table_relay_select_core_tb;
   import ntrs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomBeats = 1880;
   localparam int IdleLimit   = 2000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_command = '0;
   logic [31:0] req_node_address = '0;
   logic [63:0] req_cell_hash = '0;
   logic [8:0]  req_heading = '0;
   logic [1:0]  req_cell_row = '0;
   logic [1:0]  req_cell_column = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_entry_index;
   logic [63:0] rsp_found_hash;
   logic [1:0]  rsp_dwell_time;
   int          fail_count, pending, rsp_seen;
   int          idle_cycles;
   int          sent;

   // small pools so lookups and grid hits happen often
   logic [31:0] addr_pool [8];
   logic [63:0] hash_pool [8];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   neighbor_table_relay_select_core dut (.*);

   neighbor_table_relay_select_checker chk (.*);

   // watchdog on cycles without any accepted beat or result strobe
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // drive one command beat and hold it until accepted
   // with no gap, start stays high straight into the next beat
   task automatic send_beat(logic [2:0] cmd, logic [31:0] a, logic [63:0] h,
         logic [8:0] hd, logic [1:0] r, logic [1:0] c);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_command <= cmd;
      req_node_address <= a;
      req_cell_hash <= h;
      req_heading <= hd;
      req_cell_row <= r;
      req_cell_column <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   function automatic logic [63:0] rand_hash();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      logic [2:0]  cmd;
      logic [63:0] h;
      int pick;
      idle_cycles = 0;
      sent = 0;
      foreach (addr_pool[k]) begin
         addr_pool[k] = $urandom();
         hash_pool[k] = rand_hash();
      end
      addr_pool[0] = '1;
      hash_pool[0] = '1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty searches, extremes, grid edge cases
      send_beat(CMD_LOOKUP, '0, '0, '0, 2'd0, 2'd0);
      send_beat(CMD_FIRST, '0, '0, '0, 2'd0, 2'd0);
      send_beat(CMD_BEST, '0, '0, '0, 2'd0, 2'd0);
      send_beat(CMD_APPEND, '1, '1, 9'd359, 2'd0, 2'd0);
      send_beat(CMD_APPEND, '0, '0, 9'd0, 2'd0, 2'd0);
      send_beat(CMD_APPEND, 32'h1234_5678, 64'hA5, 9'd511, 2'd0, 2'd0);
      send_beat(CMD_FIRST, '0, '0, '0, 2'd0, 2'd0);
      send_beat(CMD_GRID, '0, '1, '0, 2'd2, 2'd2);
      send_beat(CMD_GRID, '0, 64'hA5, '0, 2'd3, 2'd1);
      send_beat(CMD_GRID, '0, 64'hA5, '0, 2'd1, 2'd3);
      send_beat(CMD_LOOKUP, '1, '0, '0, 2'd0, 2'd0);
      send_beat(CMD_LOOKUP, 32'h1234_5678, '0, '0, 2'd0, 2'd0);
      send_beat(CMD_FIRST, '0, '0, '0, 2'd0, 2'd0);
      send_beat(CMD_BEST, '0, '0, '0, 2'd0, 2'd0);
      send_beat(3'd6, '1, '1, '1, 2'd3, 2'd3);
      send_beat(3'd7, '0, '0, '0, 2'd0, 2'd0);
      // fill past the end so the full status shows
      for (int i = 0; i < 66; i++)
         send_beat(CMD_APPEND, addr_pool[i % 8], hash_pool[i % 8],
                   9'($urandom_range(0, 511)), 2'd0, 2'd0);
      send_beat(CMD_BEST, '0, '0, '0, 2'd0, 2'd0);
      send_beat(CMD_CLEAR, '0, '0, '0, 2'd0, 2'd0);
      send_beat(CMD_BEST, '0, '0, '0, 2'd0, 2'd0);
      start <= 0;

      // hold off until every expected result is back
      while (pending != 0) @(posedge clock);
      repeat (70) @(posedge clock);

      // random: mostly pooled values so searches hit, rest noise
      for (int n = 0; n < RandomBeats; n++) begin
         pick = $urandom_range(0, 99);
         h = $urandom_range(0, 4) == 0 ? rand_hash() : hash_pool[$urandom_range(0, 7)];
         if (pick < 3) cmd = CMD_CLEAR;
         else if (pick < 40) cmd = CMD_APPEND;
         else if (pick < 55) cmd = CMD_GRID;
         else if (pick < 70) cmd = CMD_LOOKUP;
         else if (pick < 80) cmd = CMD_FIRST;
         else if (pick < 97) cmd = CMD_BEST;
         else cmd = 3'($urandom_range(6, 7));
         send_beat(cmd,
                   $urandom_range(0, 4) == 0 ? $urandom() : addr_pool[$urandom_range(0, 7)],
                   h, 9'($urandom_range(0, 9) == 0 ? $urandom_range(360, 511)
                                                   : $urandom_range(0, 359)),
                   2'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)),
                   2'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)));
      end
      start <= 0;

      while (pending != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      $display("covered %0d command beats, %0d result beats, incl. full table and grid",
               sent, rsp_seen);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

[sim.f]
sv/ntrs_pkg.sv
sv/ntrs_ram.sv
sv/ntrs_grid.sv
sv/neighbor_table_relay_select_core.sv
sv/ntrs_checker.sv
bench/neighbor_table_relay_select_checker.sv
bench/neighbor_table_relay_select_core_tb.sv
